@@ hw/rtl/bpfl_pkg.sv @@
// bpfl_pkg: shared sizes, codes and payload types of the block pool allocator.
// Used by bpfl_ctrl, bpfl_dp and block_pool_free_list_allocator; depends on nothing.
package bpfl_pkg;

  // pool geometry
  localparam int MAX_BLOCKS    = 16;
  localparam int MAX_PER_BLOCK = 64;
  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int NODE_W  = $clog2(MAX_PER_BLOCK);
  localparam int SLOT_W  = BLK_W + NODE_W;
  localparam int CNT_W   = $clog2(MAX_PER_BLOCK + 1);
  localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);
  localparam int TOTAL_SLOTS = MAX_BLOCKS * MAX_PER_BLOCK;

  // size register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] OPB_RESET = CFG_W'(MAX_PER_BLOCK);

  // end-of-list mark held in the link of the last slot
  localparam logic [CNT_W-1:0] LIST_END = CNT_W'(MAX_PER_BLOCK);

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_BAD_SLOT    = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [SLOT_W-1:0]  slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    status_t            status;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch the request beat
    logic use_in;  // address memories from the input port
    logic exec;    // finish the request
    logic link;    // link one slot of the block being activated
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_act;   // allocate found no partial block, a new one is available
    logic link_last;  // last slot of the block is being linked
  } ctrl_sts_t;

endpackage

@@ hw/rtl/bpfl_ctrl.sv @@
// bpfl_ctrl: sequencing state machine of the block pool allocator.
// Depends on bpfl_pkg; drives bpfl_dp through ctrl_cmd_t.
module bpfl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bpfl_pkg::ctrl_sts_t   sts,
  output bpfl_pkg::ctrl_cmd_t   cmd
);

  bpfl_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpfl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      bpfl_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.use_in = 1'b1;
        cmd.accept = start;
        if (start) begin
          state_nxt = bpfl_pkg::S_EXEC;
        end
      end
      bpfl_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        // empty stack with blocks left: activate one, then retry
        state_nxt = sts.need_act ? bpfl_pkg::S_LINK : bpfl_pkg::S_IDLE;
      end
      bpfl_pkg::S_LINK: begin
        cmd.link = 1'b1;
        if (sts.link_last) begin
          state_nxt = bpfl_pkg::S_READ;
        end
      end
      bpfl_pkg::S_READ: begin
        // memory read of the new head slot
        state_nxt = bpfl_pkg::S_EXEC;
      end
      default: begin
        state_nxt = bpfl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/bpfl_dp.sv @@
// bpfl_dp: datapath of the block pool allocator: slot memories, per-block
// heads and counts, partial-block stack, size register and result register.
// Depends on bpfl_pkg; commanded by bpfl_ctrl.
module bpfl_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bpfl_pkg::ctrl_cmd_t              cmd,
  output bpfl_pkg::ctrl_sts_t              sts,
  input  bpfl_pkg::in_t                    in_req,
  input  logic                             cfg_valid,
  input  logic [bpfl_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  output bpfl_pkg::out_t                   out_rsp
);

  localparam int BW = bpfl_pkg::BLK_W;
  localparam int NW = bpfl_pkg::NODE_W;
  localparam int CW = bpfl_pkg::CNT_W;
  localparam int DW = bpfl_pkg::DEPTH_W;
  localparam int SW = bpfl_pkg::SLOT_W;

  // slot memories (no reset: every entry read was written at activation)
  logic          slot_free_r [bpfl_pkg::TOTAL_SLOTS];
  logic [CW-1:0] next_free_r [bpfl_pkg::TOTAL_SLOTS];
  logic          sf_q_r;
  logic [CW-1:0] nf_q_r;

  // per-block state and stack
  logic [CW-1:0] head_r  [bpfl_pkg::MAX_BLOCKS];
  logic [CW-1:0] cnt_r   [bpfl_pkg::MAX_BLOCKS];
  logic [BW-1:0] stack_r [bpfl_pkg::MAX_BLOCKS];

  // control registers
  logic [DW-1:0]              depth_r, depth_nxt;
  logic [DW-1:0]              active_r, active_nxt;
  logic [bpfl_pkg::CFG_W-1:0] opb_r, opb_nxt;
  logic [NW-1:0]              link_n_r, link_n_nxt;
  bpfl_pkg::in_t              req_r;
  logic                       out_valid_r, out_valid_nxt;
  bpfl_pkg::out_t             out_rsp_r, out_rsp_nxt;

  // memory write ports
  logic          sf_we, sf_wd, nf_we;
  logic [SW-1:0] sf_wa, nf_wa;
  logic [CW-1:0] nf_wd;
  logic          head_we, cnt_we, stack_we;
  logic [BW-1:0] head_wa, cnt_wa, stack_wa;
  logic [CW-1:0] head_wd, cnt_wd;
  logic [BW-1:0] stack_wd;

  // derived values
  bpfl_pkg::in_t rd_req;
  logic [BW-1:0] top_b;
  logic [CW-1:0] top_head;
  logic [NW-1:0] top_node;
  logic [SW-1:0] alloc_idx, rd_addr;
  logic [BW-1:0] fr_b;
  logic [NW-1:0] fr_node;
  logic          fr_bad;
  logic [BW-1:0] act_b;
  logic [CW-1:0] link_succ;
  logic [CW-1:0] cnt_dec, cnt_inc;
  logic [bpfl_pkg::CFG_W-1:0] cfg_clamped;

  // top of the partial-block stack and its head slot
  always_comb begin
    top_b    = stack_r[BW'(depth_r - DW'(1))];
    top_head = head_r[top_b];
    top_node = (top_head >= bpfl_pkg::LIST_END) ? '0 : top_head[NW-1:0];
    alloc_idx = {top_b, top_node};
  end

  // read address: from the port while idle, from the held beat otherwise
  assign rd_req  = cmd.use_in ? in_req : req_r;
  assign rd_addr = (rd_req.func == bpfl_pkg::FN_ALLOC) ? alloc_idx : rd_req.slot;

  // free request decode
  assign fr_b    = req_r.slot[SW-1:NW];
  assign fr_node = req_r.slot[NW-1:0];
  assign fr_bad  = (DW'(fr_b) >= active_r) ||
                   (bpfl_pkg::CFG_W'(fr_node) >= opb_r);

  // activation sweep
  assign act_b          = active_r[BW-1:0];
  assign link_succ      = CW'(link_n_r) + CW'(1);
  assign sts.link_last  = (link_succ == CW'(opb_r));
  assign sts.need_act   = (req_r.func == bpfl_pkg::FN_ALLOC) && (depth_r == '0) &&
                          (active_r < DW'(bpfl_pkg::MAX_BLOCKS));

  assign cnt_dec = (cnt_r[top_b] != '0) ? cnt_r[top_b] - CW'(1) : cnt_r[top_b];
  assign cnt_inc = cnt_r[fr_b] + CW'(1);

  // size write clamped to 1..MAX_PER_BLOCK
  always_comb begin
    priority if (cfg_data == '0) begin
      cfg_clamped = bpfl_pkg::CFG_W'(1);
    end else if (cfg_data > bpfl_pkg::OPB_RESET) begin
      cfg_clamped = bpfl_pkg::OPB_RESET;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  // request execution and activation
  always_comb begin
    sf_we = 1'b0; sf_wa = rd_addr; sf_wd = 1'b0;
    nf_we = 1'b0; nf_wa = rd_addr; nf_wd = '0;
    head_we = 1'b0; head_wa = top_b; head_wd = '0;
    cnt_we  = 1'b0; cnt_wa  = top_b; cnt_wd  = '0;
    stack_we = 1'b0; stack_wa = depth_r[BW-1:0]; stack_wd = '0;
    depth_nxt  = depth_r;
    active_nxt = active_r;
    link_n_nxt = link_n_r;
    opb_nxt    = opb_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    // size register locks once a block is active
    if (cfg_valid && active_r == '0) begin
      opb_nxt = cfg_clamped;
    end

    if (cmd.link) begin
      // link one slot; the last one ends the list
      sf_we = 1'b1; sf_wa = {act_b, link_n_r}; sf_wd = 1'b1;
      nf_we = 1'b1; nf_wa = {act_b, link_n_r};
      nf_wd = sts.link_last ? bpfl_pkg::LIST_END : link_succ;
      link_n_nxt = link_n_r + NW'(1);
      if (sts.link_last) begin
        link_n_nxt = '0;
        head_we = 1'b1; head_wa = act_b; head_wd = '0;
        cnt_we  = 1'b1; cnt_wa  = act_b; cnt_wd  = CW'(opb_r);
        stack_we = 1'b1; stack_wd = act_b;
        depth_nxt  = depth_r + DW'(1);
        active_nxt = active_r + DW'(1);
      end
    end else if (cmd.exec && !sts.need_act) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt.granted_slot = '0;
      out_rsp_nxt.status       = bpfl_pkg::ST_OK;
      if (req_r.func == bpfl_pkg::FN_ALLOC) begin
        if (depth_r == '0) begin
          out_rsp_nxt.status = bpfl_pkg::ST_EXHAUSTED;
        end else begin
          // pop the head slot of the top block
          sf_we = 1'b1; sf_wa = alloc_idx; sf_wd = 1'b0;
          head_we = 1'b1; head_wa = top_b; head_wd = nf_q_r;
          cnt_we  = 1'b1; cnt_wa  = top_b; cnt_wd  = cnt_dec;
          if (cnt_dec == '0) begin
            depth_nxt = depth_r - DW'(1);
          end
          out_rsp_nxt.granted_slot = alloc_idx;
        end
      end else begin
        if (fr_bad) begin
          out_rsp_nxt.status = bpfl_pkg::ST_BAD_SLOT;
        end else if (sf_q_r) begin
          out_rsp_nxt.status = bpfl_pkg::ST_DOUBLE_FREE;
        end else begin
          // push the slot on its block's list
          sf_we = 1'b1; sf_wa = req_r.slot; sf_wd = 1'b1;
          nf_we = 1'b1; nf_wa = req_r.slot; nf_wd = head_r[fr_b];
          head_we = 1'b1; head_wa = fr_b; head_wd = CW'(fr_node);
          cnt_we  = 1'b1; cnt_wa  = fr_b; cnt_wd  = cnt_inc;
          if (cnt_inc == CW'(1) && depth_r < DW'(bpfl_pkg::MAX_BLOCKS)) begin
            stack_we  = 1'b1; stack_wd = fr_b;
            depth_nxt = depth_r + DW'(1);
          end
        end
      end
    end
  end

  // slot memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (sf_we) begin
      slot_free_r[sf_wa] <= sf_wd;
    end
    if (nf_we) begin
      next_free_r[nf_wa] <= nf_wd;
    end
    sf_q_r <= slot_free_r[rd_addr];
    nf_q_r <= next_free_r[rd_addr];
  end

  // per-block registers and payload
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[head_wa] <= head_wd;
    end
    if (cnt_we) begin
      cnt_r[cnt_wa] <= cnt_wd;
    end
    if (stack_we) begin
      stack_r[stack_wa] <= stack_wd;
    end
    if (cmd.accept) begin
      req_r <= in_req;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      active_r    <= '0;
      opb_r       <= bpfl_pkg::OPB_RESET;
      link_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      active_r    <= active_nxt;
      opb_r       <= opb_nxt;
      link_n_r    <= link_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

@@ hw/rtl/block_pool_free_list_allocator.sv @@
// Block pool allocator top: request strobe in, one result strobe per request out.
// Each request is latched in IDLE, executed in EXEC and its result registered; busy
// holds off a new request until the controller is back in IDLE, since the slot
// memories have a registered read. An allocate that activates a block first runs the
// LINK sweep, one slot per cycle, then READ, before EXEC retries. Results cannot be stalled.
// Reset clears control state only; list memories are written at activation.
module block_pool_free_list_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  bpfl_pkg::in_t               in_req,
  output logic                        out_valid,
  output bpfl_pkg::out_t              out_rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bpfl_pkg::CFG_W-1:0]  cfg_data
);

  bpfl_pkg::ctrl_cmd_t cmd;
  bpfl_pkg::ctrl_sts_t sts;

  // size writes always taken; ignored by the datapath once a block is active
  assign cfg_ready = 1'b1;

  bpfl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bpfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

@@ test/block_pool_free_list_allocator_tb.sv @@
// Self-checking testbench for block_pool_free_list_allocator: a predictor of the
// block pool, directed and random request beats, and a result checker.
// Depends on bpfl_pkg and the allocator RTL only.
module block_pool_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfl_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_req;
  logic             out_valid;
  out_t             out_rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  block_pool_free_list_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock, 8 ns period
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // predicted pool state
  bit               pm_slot_free [TOTAL_SLOTS];
  logic [CNT_W-1:0] pm_next      [TOTAL_SLOTS];
  logic [CNT_W-1:0] pm_head      [MAX_BLOCKS];
  logic [CNT_W-1:0] pm_free_cnt  [MAX_BLOCKS];
  logic [BLK_W-1:0] pm_stack     [MAX_BLOCKS];
  logic [DEPTH_W-1:0] pm_depth;
  logic [DEPTH_W-1:0] pm_active;
  logic [CFG_W-1:0]   pm_size;

  out_t              pending_rsp [$];
  logic [SLOT_W-1:0] live_slots  [$];
  int                fail_count;

  // sender pacing
  int burst_left;
  int burst_gap;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (v > CFG_W'(MAX_PER_BLOCK)) return CFG_W'(MAX_PER_BLOCK);
    return v;
  endfunction

  // size register is locked once any block has been activated
  function automatic void pool_write_size(input logic [CFG_W-1:0] v);
    if (pm_active == '0) pm_size = clamp_size(v);
  endfunction

  function automatic void drop_live(input logic [SLOT_W-1:0] s);
    for (int i = 0; i < live_slots.size(); i++) begin
      if (live_slots[i] == s) begin
        live_slots.delete(i);
        return;
      end
    end
  endfunction

  // one request against the predicted pool; returns the expected result
  function automatic out_t pool_step(input in_t req);
    out_t             rsp;
    int               b;
    int               node;
    int               idx;
    int               base;
    rsp.granted_slot = '0;
    rsp.status       = ST_OK;
    if (req.func == FN_ALLOC) begin
      if (pm_depth == '0 && pm_active >= MAX_BLOCKS) begin
        rsp.status = ST_EXHAUSTED;
      end else begin
        // stack empty: bring up the next block, linked in slot order
        if (pm_depth == '0) begin
          b    = int'(pm_active);
          base = b * MAX_PER_BLOCK;
          for (int n = 0; n < MAX_PER_BLOCK; n++) begin
            pm_slot_free[base + n] = (n < pm_size);
            pm_next[base + n] = (n < pm_size && n + 1 < pm_size) ? CNT_W'(n + 1) : LIST_END;
          end
          pm_head[b]     = '0;
          pm_free_cnt[b] = CNT_W'(pm_size);
          pm_stack[pm_depth] = BLK_W'(b);
          pm_depth  = pm_depth + DEPTH_W'(1);
          pm_active = pm_active + DEPTH_W'(1);
        end
        b    = int'(pm_stack[pm_depth - DEPTH_W'(1)]);
        node = int'(pm_head[b]);
        if (node >= MAX_PER_BLOCK) node = 0;
        idx  = b * MAX_PER_BLOCK + node;
        pm_head[b]        = pm_next[idx];
        pm_slot_free[idx] = 1'b0;
        if (pm_free_cnt[b] > 0) pm_free_cnt[b] = pm_free_cnt[b] - CNT_W'(1);
        if (pm_free_cnt[b] == 0) pm_depth = pm_depth - DEPTH_W'(1);
        rsp.granted_slot = SLOT_W'(idx);
        live_slots = {live_slots, SLOT_W'(idx)};
      end
    end else begin
      b    = int'(req.slot[SLOT_W-1:NODE_W]);
      node = int'(req.slot[NODE_W-1:0]);
      if (b >= pm_active || node >= pm_size) begin
        rsp.status = ST_BAD_SLOT;
      end else if (pm_slot_free[req.slot]) begin
        rsp.status = ST_DOUBLE_FREE;
      end else begin
        pm_slot_free[req.slot] = 1'b1;
        pm_next[req.slot]      = pm_head[b];
        pm_head[b]             = CNT_W'(node);
        pm_free_cnt[b]         = pm_free_cnt[b] + CNT_W'(1);
        // block regains a free slot: back on the stack
        if (pm_free_cnt[b] == 1 && pm_depth < MAX_BLOCKS) begin
          pm_stack[pm_depth] = BLK_W'(b);
          pm_depth = pm_depth + DEPTH_W'(1);
        end
        drop_live(req.slot);
      end
    end
    return rsp;
  endfunction

  // drive one request beat, hold it until accepted, then record the prediction
  task automatic issue_req(input func_t f, input logic [SLOT_W-1:0] s);
    in_t  req;
    out_t exp_rsp;
    req.func = f;
    req.slot = s;
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    exp_rsp     = pool_step(req);
    pending_rsp = {pending_rsp, exp_rsp};
    // bursts with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      burst_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (burst_left == 0 && burst_gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (burst_gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and let every outstanding result arrive
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    pool_write_size(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker: one beat per out_valid cycle
  always @(posedge clk) begin
    out_t exp_rsp;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result beat granted_slot=%0d status=%0d",
                 $time, out_rsp.granted_slot, out_rsp.status);
        fail_count++;
      end else begin
        exp_rsp = pending_rsp[0];
        pending_rsp.delete(0);
        if (out_rsp.granted_slot !== exp_rsp.granted_slot) begin
          $display("%0t: granted_slot mismatch expected=%0d actual=%0d",
                   $time, exp_rsp.granted_slot, out_rsp.granted_slot);
          fail_count++;
        end
        if (out_rsp.status !== exp_rsp.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, exp_rsp.status, out_rsp.status);
          fail_count++;
        end
      end
    end
  end

  // size register: both clamps, then the size this run works with
  task automatic test_size_register();
    int sel;
    sel = $urandom_range(0, 9);
    write_size(CFG_W'(127));
    write_size(CFG_W'(0));
    write_size(CFG_W'(MAX_PER_BLOCK));
    if (sel < 3) write_size(CFG_W'(0));
    else if (sel < 5) write_size(CFG_W'($urandom_range(MAX_PER_BLOCK, 127)));
    else write_size(CFG_W'($urandom_range(2, 12)));
  endtask

  // directed: first activation, double free, bad slots, block refill and reuse
  task automatic test_directed_ops();
    int sz;
    sz = int'(pm_size);
    issue_req(FN_ALLOC, SLOT_W'(1023));
    issue_req(FN_FREE, SLOT_W'(0));
    issue_req(FN_FREE, SLOT_W'(0));
    issue_req(FN_FREE, SLOT_W'(1023));
    issue_req(FN_FREE, SLOT_W'(sz));
    issue_req(FN_FREE, SLOT_W'(MAX_PER_BLOCK - 1));
    if (sz <= 12) begin
      // fill block 0, then one more to force the next activation
      for (int i = 0; i <= sz; i++) issue_req(FN_ALLOC, '0);
      issue_req(FN_FREE, SLOT_W'(0));
      issue_req(FN_ALLOC, '0);
      issue_req(FN_FREE, SLOT_W'(MAX_PER_BLOCK));
      issue_req(FN_FREE, SLOT_W'(2 * MAX_PER_BLOCK - 1));
    end
    drain();
  endtask

  // writes after activation must leave the size alone
  task automatic test_locked_size();
    drain();
    write_size(CFG_W'(0));
    write_size(CFG_W'(127));
    write_size(CFG_W'($urandom_range(0, 127)));
  endtask

  // random traffic: alternating fill and drain phases, some noise
  task automatic test_random_traffic(input int n_items);
    int  r;
    int  phase_left;
    bit  filling;
    int  blk;
    logic [SLOT_W-1:0] s;
    phase_left = 0;
    filling    = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        filling    = ~filling;
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if ((filling && r < 85) || (!filling && r < 25) || (live_slots.size() == 0 && r < 85)) begin
        issue_req(FN_ALLOC, SLOT_W'($urandom_range(0, 1023)));
      end else if (r < 90 && live_slots.size() != 0) begin
        s = live_slots[$urandom_range(0, live_slots.size() - 1)];
        issue_req(FN_FREE, s);
      end else begin
        // noise: anywhere, a slot of an active block, or past the used slots
        blk = (pm_active == 0) ? 0 : $urandom_range(0, pm_active - 1);
        case ($urandom_range(0, 2))
          0: s = SLOT_W'($urandom_range(0, 1023));
          1: s = SLOT_W'(blk * MAX_PER_BLOCK + $urandom_range(0, pm_size - 1));
          default: s = SLOT_W'(blk * MAX_PER_BLOCK + $urandom_range(pm_size, MAX_PER_BLOCK));
        endcase
        issue_req(FN_FREE, s);
      end
    end
    drain();
  endtask

  // main sequence
  initial begin
    start      = 1'b0;
    in_req     = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    fail_count = 0;
    burst_left = 0;
    burst_gap  = 0;
    pm_depth   = '0;
    pm_active  = '0;
    pm_size    = OPB_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_size_register();
    test_directed_ops();
    test_locked_size();
    test_random_traffic(150);
    test_locked_size();
    test_random_traffic(150);
    test_locked_size();
    test_random_traffic(150);

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bpfl_pkg.sv
hw/rtl/bpfl_ctrl.sv
hw/rtl/bpfl_dp.sv
hw/rtl/block_pool_free_list_allocator.sv
test/block_pool_free_list_allocator_tb.sv
